### sv/ta3_pkg.sv
// Package for the triangle area pipeline: widths of every datapath stage
// and the transfer payload types. No dependencies.
package ta3_pkg;

	localparam int COORD_W = 16;
	localparam int FRAC_W  = 8;
	localparam int AREA_W  = 25;

	localparam int DIFF_W  = COORD_W;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int EDGE_W  = SUM_W / 2;
	localparam int P_W     = EDGE_W + 2;
	localparam int T_W     = P_W + 1;
	localparam int X_W     = 2 * P_W;
	localparam int H_W     = X_W / 2;
	localparam int PP_W    = 2 * H_W;
	localparam int RAD_W   = 2 * X_W;
	localparam int ROOT_W  = X_W;
	localparam int SHIFT   = FRAC_W + 2;

	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	typedef struct packed {
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] a_z;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic signed [COORD_W-1:0] b_z;
		logic signed [COORD_W-1:0] c_x;
		logic signed [COORD_W-1:0] c_y;
		logic signed [COORD_W-1:0] c_z;
	} tri_in_t;

	typedef struct packed {
		logic [AREA_W-1:0] area;
	} tri_out_t;

endpackage

### sv/ta3_if.sv
// Valid/ready channel interfaces for corner points and area results.
// Depends on ta3_pkg.
interface ta3_in_if;
	import ta3_pkg::*;
	logic    valid;
	logic    ready;
	tri_in_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ta3_out_if;
	import ta3_pkg::*;
	logic     valid;
	logic     ready;
	tri_out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### sv/triangle_area_3d.sv
// Triangle area in 3D by Heron's formula, fully pipelined.
// Throughput one item per cycle while results are taken.
// The two bit-serial square roots (17 and 38 steps) set the depth.
// The whole pipeline advances together and holds when the result is not taken.
// Reset clears all valid bits; the data path is not reset.
// Depends on ta3_pkg and ta3_if.
module triangle_area_3d (
	input  logic clk,
	input  logic arst_n,
	ta3_in_if.sink    pts,
	ta3_out_if.source result
);
	import ta3_pkg::*;

	logic en;

	logic              v_s1;
	logic [DIFF_W-1:0] absd_s1 [9];
	logic              v_s2;
	logic [SQ_W-1:0]   sq_s2 [9];

	logic                ev_s [EDGE_W+1];
	logic [SUM_W-1:0]    erad_s  [EDGE_W+1][3];
	logic [EDGE_W+1:0]   erem_s  [EDGE_W+1][3];
	logic [EDGE_W-1:0]   eroot_s [EDGE_W+1][3];
	logic [SUM_W-1:0]    erad_n  [EDGE_W][3];
	logic [EDGE_W+1:0]   erem_n  [EDGE_W][3];
	logic [EDGE_W-1:0]   eroot_n [EDGE_W][3];
	logic [EDGE_W+1:0]   erx     [EDGE_W][3];
	logic [EDGE_W+1:0]   etr     [EDGE_W][3];

	logic                  v_s4;
	logic [P_W-1:0]        p_s4;
	logic signed [T_W-1:0] t_s4 [3];
	logic                  v_s5, pos_s5;
	logic [X_W-1:0]        x_s5, y_s5;
	logic                  v_s6, pos_s6;
	logic [PP_W-1:0]       pp_s6 [4];

	logic                av_s   [ROOT_W+1];
	logic                apos_s [ROOT_W+1];
	logic [RAD_W-1:0]    arad_s  [ROOT_W+1];
	logic [ROOT_W+1:0]   arem_s  [ROOT_W+1];
	logic [ROOT_W-1:0]   aroot_s [ROOT_W+1];
	logic [RAD_W-1:0]    arad_n  [ROOT_W];
	logic [ROOT_W+1:0]   arem_n  [ROOT_W];
	logic [ROOT_W-1:0]   aroot_n [ROOT_W];
	logic [ROOT_W+1:0]   arx     [ROOT_W];
	logic [ROOT_W+1:0]   atr     [ROOT_W];

	logic [ROOT_W-1:0] root_fin;
	logic [AREA_W-1:0] area_n;
	logic              pos_n;

	function automatic logic [DIFF_W-1:0] absdiff(
		input logic signed [COORD_W-1:0] p,
		input logic signed [COORD_W-1:0] q
	);
		logic signed [COORD_W:0] d;
		logic signed [COORD_W:0] m;
		d = {q[COORD_W-1], q} - {p[COORD_W-1], p};
		m = d[COORD_W] ? -d : d;
		return m[DIFF_W-1:0];
	endfunction

	assign en        = !result.valid || result.ready;
	assign pts.ready = en;

	// edge length root steps
	always_comb begin
		for (int k = 0; k < EDGE_W; k++) begin
			for (int j = 0; j < 3; j++) begin
				erx[k][j] = {erem_s[k][j][EDGE_W-1:0], erad_s[k][j][SUM_W-1 -: 2]};
				etr[k][j] = {eroot_s[k][j], 2'b01};
				erad_n[k][j] = erad_s[k][j] << 2;
				if (erx[k][j] >= etr[k][j]) begin
					erem_n[k][j]  = erx[k][j] - etr[k][j];
					eroot_n[k][j] = {eroot_s[k][j][EDGE_W-2:0], 1'b1};
				end else begin
					erem_n[k][j]  = erx[k][j];
					eroot_n[k][j] = {eroot_s[k][j][EDGE_W-2:0], 1'b0};
				end
			end
		end
	end

	// area root steps
	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			arx[k] = {arem_s[k][ROOT_W-1:0], arad_s[k][RAD_W-1 -: 2]};
			atr[k] = {aroot_s[k], 2'b01};
			arad_n[k] = arad_s[k] << 2;
			if (arx[k] >= atr[k]) begin
				arem_n[k]  = arx[k] - atr[k];
				aroot_n[k] = {aroot_s[k][ROOT_W-2:0], 1'b1};
			end else begin
				arem_n[k]  = arx[k];
				aroot_n[k] = {aroot_s[k][ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root_fin = aroot_s[ROOT_W];
	assign pos_n    = apos_s[ROOT_W];
	always_comb begin
		if (!pos_n) begin
			area_n = '0;
		end else if (|root_fin[ROOT_W-1:SHIFT+AREA_W]) begin
			area_n = AREA_MAX;
		end else begin
			area_n = root_fin[SHIFT +: AREA_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			v_s6         <= 1'b0;
			result.valid <= 1'b0;
			for (int k = 0; k <= EDGE_W; k++) ev_s[k] <= 1'b0;
			for (int k = 0; k <= ROOT_W; k++) av_s[k] <= 1'b0;
		end else if (en) begin
			v_s1    <= pts.valid;
			v_s2    <= v_s1;
			ev_s[0] <= v_s2;
			for (int k = 0; k < EDGE_W; k++) ev_s[k+1] <= ev_s[k];
			v_s4    <= ev_s[EDGE_W];
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			av_s[0] <= v_s6;
			for (int k = 0; k < ROOT_W; k++) av_s[k+1] <= av_s[k];
			result.valid <= av_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			absd_s1[0] <= absdiff(pts.data.a_x, pts.data.b_x);
			absd_s1[1] <= absdiff(pts.data.a_y, pts.data.b_y);
			absd_s1[2] <= absdiff(pts.data.a_z, pts.data.b_z);
			absd_s1[3] <= absdiff(pts.data.b_x, pts.data.c_x);
			absd_s1[4] <= absdiff(pts.data.b_y, pts.data.c_y);
			absd_s1[5] <= absdiff(pts.data.b_z, pts.data.c_z);
			absd_s1[6] <= absdiff(pts.data.a_x, pts.data.c_x);
			absd_s1[7] <= absdiff(pts.data.a_y, pts.data.c_y);
			absd_s1[8] <= absdiff(pts.data.a_z, pts.data.c_z);

			for (int i = 0; i < 9; i++) sq_s2[i] <= absd_s1[i] * absd_s1[i];

			for (int j = 0; j < 3; j++) begin
				erad_s[0][j]  <= SUM_W'(sq_s2[3*j]) + SUM_W'(sq_s2[3*j+1])
					+ SUM_W'(sq_s2[3*j+2]);
				erem_s[0][j]  <= '0;
				eroot_s[0][j] <= '0;
			end
			for (int k = 0; k < EDGE_W; k++) begin
				for (int j = 0; j < 3; j++) begin
					erad_s[k+1][j]  <= erad_n[k][j];
					erem_s[k+1][j]  <= erem_n[k][j];
					eroot_s[k+1][j] <= eroot_n[k][j];
				end
			end

			p_s4 <= P_W'(eroot_s[EDGE_W][0]) + P_W'(eroot_s[EDGE_W][1])
				+ P_W'(eroot_s[EDGE_W][2]);
			for (int j = 0; j < 3; j++) begin
				t_s4[j] <= $signed(T_W'(eroot_s[EDGE_W][0]) + T_W'(eroot_s[EDGE_W][1])
					+ T_W'(eroot_s[EDGE_W][2])) - $signed({eroot_s[EDGE_W][j], 1'b0}
					& {T_W{1'b1}});
			end

			pos_s5 <= !t_s4[0][T_W-1] && (t_s4[0] != '0)
				&& !t_s4[1][T_W-1] && (t_s4[1] != '0)
				&& !t_s4[2][T_W-1] && (t_s4[2] != '0);
			x_s5 <= p_s4 * t_s4[0][P_W-1:0];
			y_s5 <= t_s4[1][P_W-1:0] * t_s4[2][P_W-1:0];

			pos_s6   <= pos_s5;
			pp_s6[0] <= x_s5[H_W-1:0] * y_s5[H_W-1:0];
			pp_s6[1] <= x_s5[X_W-1:H_W] * y_s5[H_W-1:0];
			pp_s6[2] <= x_s5[H_W-1:0] * y_s5[X_W-1:H_W];
			pp_s6[3] <= x_s5[X_W-1:H_W] * y_s5[X_W-1:H_W];

			apos_s[0]  <= pos_s6;
			arad_s[0]  <= RAD_W'(pp_s6[0]) + (RAD_W'(pp_s6[1]) << H_W)
				+ (RAD_W'(pp_s6[2]) << H_W) + (RAD_W'(pp_s6[3]) << (2*H_W));
			arem_s[0]  <= '0;
			aroot_s[0] <= '0;
			for (int k = 0; k < ROOT_W; k++) begin
				apos_s[k+1]  <= apos_s[k];
				arad_s[k+1]  <= arad_n[k];
				arem_s[k+1]  <= arem_n[k];
				aroot_s[k+1] <= aroot_n[k];
			end

			result.data.area <= area_n;
		end
	end

endmodule

### bench/triangle_area_3d_test.sv
// Testbench for triangle_area_3d: drives corner triples through the valid/ready
// channels and compares each area with a Heron's formula predictor.
// Depends on ta3_pkg, ta3_if and the triangle_area_3d RTL.
`timescale 1ns / 1ps

module triangle_area_3d_test;
	import ta3_pkg::*;

	localparam int PIPE_DEPTH = 63;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_COUNT = 1000;

	class area_scoreboard;
		logic [AREA_W-1:0] expected_areas[$];
		int mismatches;

		function automatic logic [127:0] root_floor(logic [127:0] v);
			logic [127:0] r;
			logic [127:0] cand;
			r = 0;
			for (int b = 63; b >= 0; b--) begin
				cand = r | (128'd1 << b);
				if (cand * cand <= v)
					r = cand;
			end
			return r;
		endfunction

		function automatic logic [63:0] edge_len(longint px, longint py, longint pz,
				longint qx, longint qy, longint qz);
			logic [127:0] s;
			s = (qx - px) * (qx - px) + (qy - py) * (qy - py) + (qz - pz) * (qz - pz);
			return 64'(root_floor(s));
		endfunction

		function automatic logic [AREA_W-1:0] heron_area(tri_in_t t);
			longint ab, bc, ac, p, t1, t2, t3;
			logic [127:0] rad;
			logic [127:0] ar;
			ab = edge_len(t.a_x, t.a_y, t.a_z, t.b_x, t.b_y, t.b_z);
			bc = edge_len(t.b_x, t.b_y, t.b_z, t.c_x, t.c_y, t.c_z);
			ac = edge_len(t.a_x, t.a_y, t.a_z, t.c_x, t.c_y, t.c_z);
			p = ab + bc + ac;
			t1 = p - 2 * ab;
			t2 = p - 2 * bc;
			t3 = p - 2 * ac;
			if (t1 <= 0 || t2 <= 0 || t3 <= 0)
				return '0;
			rad = 128'(p) * 128'(t1) * 128'(t2) * 128'(t3);
			ar = root_floor(rad) >> SHIFT;
			if (ar > 128'(AREA_MAX))
				return AREA_MAX;
			return ar[AREA_W-1:0];
		endfunction

		function void note_input(tri_in_t t);
			expected_areas.push_back(heron_area(t));
		endfunction

		function void check_result(tri_out_t r);
			logic [AREA_W-1:0] want;
			if (expected_areas.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected area %0d", r.area);
				return;
			end
			want = expected_areas.pop_front();
			if (r.area !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("area mismatch: expected %0d actual %0d", want, r.area);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	ta3_in_if pts();
	ta3_out_if result();
	area_scoreboard sb = new();
	int idle_cycles = 0;
	int sent = 0;
	bit stim_done = 0;
	bit hold_off = 0;
	tri_in_t stim_q[$];

	triangle_area_3d dut(.clk(clk), .arst_n(arst_n), .pts(pts), .result(result));

	always #5 clk = ~clk;

	initial begin
		pts.valid = 0;
		pts.data = '0;
		result.ready = 0;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 1023) - 512);
			2: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 7))
				: 16'h8000 + 16'($urandom_range(0, 7));
			default: return 16'($urandom_range(0, 31) - 16);
		endcase
	endfunction

	function automatic tri_in_t rand_tri();
		tri_in_t t;
		t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord()};
		case ($urandom_range(0, 5))
			0: t.c_x = t.a_x;
			1: begin
				// collinear: c = 2b - a
				t.a_x = 16'($urandom_range(0, 255) - 128); t.b_x = t.a_x + 16'sd3;
				t.c_x = t.b_x + 16'sd3;
				t.a_y = 16'sd10; t.b_y = 16'sd20; t.c_y = 16'sd30;
				t.a_z = 0; t.b_z = 0; t.c_z = 0;
			end
			default: ;
		endcase
		return t;
	endfunction

	task automatic send_tri(tri_in_t t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pts.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		pts.valid <= 1;
		pts.data <= t;
		do @(posedge clk); while (!pts.ready);
		sb.note_input(t);
		sent++;
	endtask

	initial begin
		tri_in_t t;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		stim_q.push_back('0);
		stim_q.push_back({9{16'sh7fff}});
		stim_q.push_back({9{16'sh8000}});
		stim_q.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000});
		stim_q.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
		stim_q.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff});
		stim_q.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
			16'sd0, 16'sd256, 16'sd0});
		stim_q.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0,
			16'sd0, 16'sd1, 16'sd0});
		stim_q.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd2, 16'sd0, 16'sd0,
			16'sd1, 16'sd1, 16'sd0});
		stim_q.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0,
			16'sd200, 16'sd1, 16'sd0});
		stim_q.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1,
			16'sd2, 16'sd2, 16'sd2});
		stim_q.push_back({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5,
			16'sd9, 16'sd1, 16'sd3});
		stim_q.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0,
			16'sd0, 16'sd0, 16'sd1});
		stim_q.push_back({16'shffff, 16'sd0, 16'sd0, 16'sd0, 16'shffff, 16'sd0,
			16'sd0, 16'sd0, 16'shffff});
		foreach (stim_q[i])
			send_tri(stim_q[i]);
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			t = rand_tri();
			send_tri(t);
		end
		pts.valid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (arst_n);
		wait (sent > 200);
		@(posedge clk);
		hold_off = 1;
		repeat (PIPE_DEPTH * 3) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		int gap;
		wait (arst_n);
		forever begin
			gap = hold_off ? 1 : pick_gap();
			if (gap > 0) begin
				result.ready <= 0;
				repeat (gap) @(posedge clk);
			end else begin
				result.ready <= 1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (result.valid && result.ready)
			sb.check_result(result.data);
		if ((pts.valid && pts.ready) || (result.valid && result.ready) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (arst_n);
		fork
			begin
				wait (stim_done && sb.expected_areas.size() == 0);
				repeat (PIPE_DEPTH + 10) @(posedge clk);
				if (sb.mismatches == 0)
					$display("SCOREBOARD CLEAN");
				else
					$display("SCOREBOARD MISMATCH");
			end
			begin
				wait (idle_cycles >= STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
			end
		join_any
		$finish;
	end
endmodule
